// ===== src/mcfp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcfp_pkg
// Types and constants shared by the motor command frame parser files.
// ---------------------------------------------------------------------------
package mcfp_pkg;

	localparam int NUM_MOTORS  = 3;
	localparam int MOTOR_SLOTS = 3;
	localparam int LIVE_MOTORS = (NUM_MOTORS < MOTOR_SLOTS) ? NUM_MOTORS : MOTOR_SLOTS;
	localparam logic [1:0] LIVE_CNT = 2'(LIVE_MOTORS);

	localparam logic [7:0] CH_LT = 8'h3C; // '<'
	localparam logic [7:0] CH_GT = 8'h3E; // '>'
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_B  = 8'h42;
	localparam logic [7:0] CH_C  = 8'h43;
	localparam logic [7:0] CH_E  = 8'h45;
	localparam logic [7:0] CH_F  = 8'h46;
	localparam logic [7:0] CH_M  = 8'h4D;

	typedef enum logic [2:0] {
		PH_START,
		PH_SECOND,
		PH_CMD,
		PH_DATA,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_ON,
		CMD_OFF,
		CMD_STATUS
	} cmd_t;

	typedef enum logic [1:0] {
		CODE_NONE,
		CODE_ON,
		CODE_OFF
	} code_t;

	typedef struct packed {
		logic       frame_done;
		logic [2:0] motor_states;
		logic [2:0] changed_mask;
	} result_t;

endpackage

// ===== src/mcfp_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcfp_in_if
// Byte channel into the parser: valid/ready handshake with one rx byte.
// ---------------------------------------------------------------------------
interface mcfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/mcfp_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcfp_out_if
// Result channel out of the parser: frame done flag, motor states, change mask.
// ---------------------------------------------------------------------------
interface mcfp_out_if;
	logic       valid;
	logic       ready;
	logic       frame_done;
	logic [2:0] motor_states;
	logic [2:0] changed_mask;

	modport source (output valid, output frame_done, output motor_states,
		output changed_mask, input ready);
	modport sink (input valid, input frame_done, input motor_states,
		input changed_mask, output ready);
endinterface

// ===== src/mcfp_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcfp_core
// Parser state and its update for one received byte, applied when step is high.
// ---------------------------------------------------------------------------
module mcfp_core
	import mcfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output result_t    res
);

	phase_t     phase_q, phase_n;
	cmd_t       cmd_q, cmd_n;
	logic [1:0] choice_q, choice_n;
	logic [1:0] entry_q, entry_n;
	code_t      pend_q [MOTOR_SLOTS];
	code_t      pend_n [MOTOR_SLOTS];
	logic [2:0] status_q, status_n;

	logic [2:0] fin_status;
	logic [2:0] fin_mask;
	logic       done;
	code_t      letter_code;

	// status and flags as they would be if the frame ended now
	always_comb begin
		fin_status = status_q;
		fin_mask   = '0;
		unique case (cmd_q)
			CMD_ON, CMD_OFF: begin
				if (choice_q < LIVE_CNT) begin
					fin_status[choice_q] = (cmd_q == CMD_OFF);
					fin_mask[choice_q]   = 1'b1;
				end
			end
			CMD_STATUS: begin
				for (int i = 0; i < MOTOR_SLOTS; i++) begin
					if (2'(i) < entry_q && 2'(i) < LIVE_CNT &&
						(pend_q[i] == CODE_ON || pend_q[i] == CODE_OFF)) begin
						if (status_q[i] != (pend_q[i] == CODE_OFF))
							fin_mask[i] = 1'b1;
						fin_status[i] = (pend_q[i] == CODE_OFF);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		letter_code = (rx_byte == CH_A) ? CODE_ON : (rx_byte == CH_M) ? CODE_OFF : CODE_NONE;
	end

	always_comb begin
		phase_n  = phase_q;
		cmd_n    = cmd_q;
		choice_n = choice_q;
		entry_n  = entry_q;
		pend_n   = pend_q;
		status_n = status_q;
		done     = 1'b0;
		unique case (phase_q)
			PH_START: begin
				cmd_n   = CMD_NONE;
				entry_n = '0;
				phase_n = (rx_byte == CH_LT) ? PH_SECOND : PH_START;
			end
			PH_SECOND: begin
				phase_n = (rx_byte == CH_M) ? PH_CMD : PH_START;
			end
			PH_CMD: begin
				priority if (rx_byte == CH_A) begin
					cmd_n   = CMD_ON;
					phase_n = PH_DATA;
				end else if (rx_byte == CH_M) begin
					cmd_n   = CMD_OFF;
					phase_n = PH_DATA;
				end else if (rx_byte == CH_E) begin
					cmd_n   = CMD_STATUS;
					phase_n = PH_DATA;
				end else begin
					phase_n = PH_START;
				end
			end
			PH_DATA: begin
				if (cmd_q == CMD_STATUS) begin
					if (rx_byte == CH_GT) begin
						done     = 1'b1;
						status_n = fin_status;
						phase_n  = PH_START;
					end else if (entry_q < LIVE_CNT) begin
						for (int i = 0; i < MOTOR_SLOTS; i++) begin
							if (2'(i) == entry_q)
								pend_n[i] = letter_code;
						end
						entry_n = entry_q + 2'd1;
					end
				end else if (rx_byte == CH_A || rx_byte == CH_B || rx_byte == CH_C) begin
					choice_n = 2'(rx_byte - CH_A);
					phase_n  = PH_END;
				end else begin
					phase_n = PH_START;
				end
			end
			PH_END: begin
				if (rx_byte == CH_GT || rx_byte == CH_F) begin
					done     = 1'b1;
					status_n = fin_status;
				end
				phase_n = PH_START;
			end
			default: begin
				phase_n = PH_START;
			end
		endcase
		res.frame_done   = done;
		res.motor_states = status_n;
		res.changed_mask = done ? fin_mask : 3'b000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			cmd_q    <= CMD_NONE;
			choice_q <= '0;
			entry_q  <= '0;
			status_q <= '0;
			for (int i = 0; i < MOTOR_SLOTS; i++)
				pend_q[i] <= CODE_NONE;
		end else if (step) begin
			phase_q  <= phase_n;
			cmd_q    <= cmd_n;
			choice_q <= choice_n;
			entry_q  <= entry_n;
			status_q <= status_n;
			pend_q   <= pend_n;
		end
	end

endmodule

// ===== src/motor_command_frame_parser_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_command_frame_parser_top
// Parses '<' 'M' cmd data frames from a byte stream and reports motor status.
// ---------------------------------------------------------------------------
//  channel  dir  beat payload
//  rx       in   rx_byte[7:0]
//  tx       out  frame_done, motor_states[2:0], changed_mask[2:0]
//
//  one result beat per byte beat; a byte can be taken every cycle while tx is not stalled
//  a byte passes through the input register, then the parser update into the result register
//  the parser state advances only when the input register moves into the result register
//  a stalled tx holds its beat; rx keeps taking bytes until the input register is full
//  reset puts the parser in start wait with all motors on
// ---------------------------------------------------------------------------
module motor_command_frame_parser_top
	import mcfp_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	mcfp_in_if.sink     rx,
	mcfp_out_if.source  tx
);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       tx_valid_q;
	result_t    res_q;
	result_t    res;
	logic       advance;

	assign advance  = v_s1 && (!tx_valid_q || tx.ready);
	assign rx.ready = !v_s1 || advance;

	mcfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			tx_valid_q <= 1'b0;
		end else begin
			if (rx.valid && rx.ready)
				v_s1 <= 1'b1;
			else if (advance)
				v_s1 <= 1'b0;
			if (advance)
				tx_valid_q <= 1'b1;
			else if (tx.ready)
				tx_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
		if (advance)
			res_q <= res;
	end

	assign tx.valid        = tx_valid_q;
	assign tx.frame_done   = res_q.frame_done;
	assign tx.motor_states = res_q.motor_states;
	assign tx.changed_mask = res_q.changed_mask;

endmodule
